### design/imh_pkg.sv
package imh_pkg;

  localparam int KIND_W   = 3;
  localparam int ID_W     = 8;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEL_MAX  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_KEY = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd5;
  localparam logic [KIND_W-1:0] KIND_PEEK_MAX = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED   = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_FETCH,
    OP_ERR,
    OP_INS,
    OP_PEEK,
    OP_DEL,
    OP_POS,
    OP_READ_S,
    OP_UPD,
    OP_REM,
    OP_RDK,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_D_RD,
    OP_D_MOVE,
    OP_PUT,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic [STATUS_W-1:0] err;
  } imh_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [KIND_W-1:0] kind;
    logic              inrange;
    logic              have;
    logic              empty;
    logic              full;
    logic              s_zero;
    logic              s_eq_cnt;
    logic              key_gt;
    logic              key_lt;
    logic              up_stop;
    logic              d_leaf;
    logic              d_stop;
    logic              out_free;
  } imh_flags_t;

endpackage

### design/imh_if.sv
interface imh_req_if import imh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   item_id;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output kind, output item_id, output key, input ready);
  modport sink (input valid, input kind, input item_id, input key, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic signed [KEY_W-1:0] key_out;
  logic [ID_W-1:0]     item_out;
  logic                present;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output key_out, output item_out,
                  output present, output count, input ready);
  modport sink (input valid, input status, input key_out, input item_out,
                input present, input count, output ready);
endinterface

### design/indexed_max_heap.sv
// Indexed binary max-heap of signed keys, each tagged by an item id, with a
// per-item slot map so that any item can be updated, removed or read. Each
// request transaction yields exactly one response transaction. Errors, peeks
// and presence tests go straight from dispatch to the response, and a key read
// first looks up the item's slot and reads its entry. A request that sifts
// walks the heap a level at a time, each level a read of the dual-read heap
// memory and then a compare-and-move step, besides the slot lookup, setup and
// the final write; the sift loop is the longest part of a request. Requests
// are handled one at a time, and a finished response waits in an output
// register, so a response that is not taken holds back the next one.
module indexed_max_heap import imh_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int ITEM_COUNT = 256,
  parameter int KEY_BITS   = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  imh_req_if.sink   req_i,
  imh_rsp_if.source rsp_o
);

  imh_cmd_t   cmd;
  imh_flags_t flags;

  imh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .cmd_o   (cmd)
  );

  imh_dp #(
    .CAPACITY   (CAPACITY),
    .ITEM_COUNT (ITEM_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .rsp     (rsp_o),
    .cmd_i   (cmd),
    .flags_o (flags)
  );

endmodule

### design/imh_ctrl.sv
module imh_ctrl import imh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  imh_flags_t flags_i,
  output imh_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RDS   = 4'd3;
  localparam logic [3:0] S_EX2   = 4'd4;
  localparam logic [3:0] S_BR    = 4'd5;
  localparam logic [3:0] S_URD   = 4'd6;
  localparam logic [3:0] S_UCMP  = 4'd7;
  localparam logic [3:0] S_DRD   = 4'd8;
  localparam logic [3:0] S_DCMP  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_IDLE;
    cmd_o.err  = ST_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.op = OP_LOAD;
        if (flags_i.in_valid) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.op = OP_FETCH;
        state_d  = S_DISP;
      end
      S_DISP: begin
        state_d = S_FIN;
        case (flags_i.kind)
          KIND_INSERT: begin
            if (!flags_i.inrange) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_ABSENT;
            end else if (flags_i.have) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_PRESENT;
            end else if (flags_i.full) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_FULL;
            end else begin
              cmd_o.op = OP_INS;
              state_d  = S_URD;
            end
          end
          KIND_DEL_MAX, KIND_PEEK_MAX: begin
            if (flags_i.empty) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_EMPTY;
            end else if (flags_i.kind == KIND_PEEK_MAX) begin
              cmd_o.op = OP_PEEK;
            end else begin
              cmd_o.op = OP_DEL;
              state_d  = S_BR;
            end
          end
          KIND_UPDATE, KIND_REMOVE, KIND_READ_KEY: begin
            if (!flags_i.have) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_ABSENT;
            end else begin
              cmd_o.op = OP_POS;
              state_d  = S_RDS;
            end
          end
          default: begin
            cmd_o.op = OP_IDLE;
          end
        endcase
      end
      S_RDS: begin
        cmd_o.op = OP_READ_S;
        state_d  = S_EX2;
      end
      S_EX2: begin
        case (flags_i.kind)
          KIND_UPDATE: begin
            cmd_o.op = OP_UPD;
            state_d  = S_BR;
          end
          KIND_REMOVE: begin
            cmd_o.op = OP_REM;
            state_d  = S_BR;
          end
          default: begin
            cmd_o.op = OP_RDK;
            state_d  = S_FIN;
          end
        endcase
      end
      S_BR: begin
        if (flags_i.s_eq_cnt) begin
          state_d = S_FIN;
        end else if (flags_i.key_gt) begin
          state_d = S_URD;
        end else if (flags_i.key_lt) begin
          state_d = S_DRD;
        end else begin
          cmd_o.op = OP_PUT;
          state_d  = S_FIN;
        end
      end
      S_URD: begin
        if (flags_i.s_zero) begin
          cmd_o.op = OP_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_UP_RD;
          state_d  = S_UCMP;
        end
      end
      S_UCMP: begin
        if (flags_i.up_stop) begin
          cmd_o.op = OP_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_UP_MOVE;
          state_d  = S_URD;
        end
      end
      S_DRD: begin
        if (flags_i.d_leaf) begin
          cmd_o.op = OP_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_D_RD;
          state_d  = S_DCMP;
        end
      end
      S_DCMP: begin
        if (flags_i.d_stop) begin
          cmd_o.op = OP_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = OP_D_MOVE;
          state_d  = S_DRD;
        end
      end
      S_FIN: begin
        if (flags_i.out_free) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && flags_i.in_valid) |=> (state_q == S_FETCH))
    else $error("Accepted transaction did not start a fetch.");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && flags_i.out_free) |=> (state_q == S_IDLE))
    else $error("Finished transaction did not return to idle.");

  a_up_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_URD && flags_i.s_zero) |=> (state_q == S_FIN))
    else $error("Sift-up continued past the root.");

endmodule

### design/imh_dp.sv
module imh_dp import imh_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int ITEM_COUNT = 256,
  parameter int KEY_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imh_req_if.sink     req,
  imh_rsp_if.source   rsp,
  input  imh_cmd_t    cmd_i,
  output imh_flags_t  flags_o
);

  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VALID_DEPTH = (ITEM_COUNT < 256) ? ITEM_COUNT : 256;
  localparam int IDX_W       = $clog2(VALID_DEPTH);
  localparam int CW          = SLOT_W + 2;
  localparam int ENT_W       = KEY_BITS + ID_W;

  logic [KIND_W-1:0]   kind_q;
  logic [ID_W-1:0]     id_q;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_BITS-1:0] hk_q, old_q, lk_q, kout_q;
  logic [ID_W-1:0]     hi_q, li_q, iout_q;
  logic [SLOT_W-1:0]   s_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [STATUS_W-1:0] status_q;
  logic [VALID_DEPTH-1:0] valid_q;

  logic [ENT_W-1:0]    heap_mem [CAPACITY];
  logic [SLOT_W-1:0]   pos_mem [VALID_DEPTH];
  logic [ENT_W-1:0]    ra_q, rb_q;
  logic [SLOT_W-1:0]   pos_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] o_status_q;
  logic [KEY_W-1:0]    o_key_q;
  logic [ID_W-1:0]     o_item_q;
  logic                o_present_q;
  logic [COUNT_W-1:0]  o_count_q;

  logic [KEY_BITS-1:0] ra_key, rb_key, key_ext, pick_key;
  logic [ID_W-1:0]     ra_item, rb_item, pick_item;
  logic [CW-1:0]       c_x, c1_x, cnt_x;
  logic [SLOT_W-1:0]   parent, pick_slot, addr_a, addr_b, last_slot;
  logic                use_b, inrange, have, heap_we, out_free;
  logic [SLOT_W-1:0]   heap_waddr;
  logic [ENT_W-1:0]    heap_wdata;
  logic [IDX_W-1:0]    id_idx;

  assign ra_key    = ra_q[ENT_W-1:ID_W];
  assign ra_item   = ra_q[ID_W-1:0];
  assign rb_key    = rb_q[ENT_W-1:ID_W];
  assign rb_item   = rb_q[ID_W-1:0];
  assign key_ext   = KEY_BITS'(signed'(key_q));
  assign c_x       = {1'b0, s_q, 1'b1};
  assign c1_x      = c_x + CW'(1);
  assign cnt_x     = CW'(cnt_q);
  assign parent    = (s_q - SLOT_W'(1)) >> 1;
  assign last_slot = SLOT_W'(cnt_q - CNT_W'(1));
  assign use_b     = (c1_x < cnt_x) && ($signed(rb_key) > $signed(ra_key));
  assign pick_key  = use_b ? rb_key : ra_key;
  assign pick_item = use_b ? rb_item : ra_item;
  assign pick_slot = use_b ? c1_x[SLOT_W-1:0] : c_x[SLOT_W-1:0];
  assign id_idx    = id_q[IDX_W-1:0];
  assign inrange   = 32'(id_q) < 32'(ITEM_COUNT);
  assign have      = inrange && valid_q[id_idx];
  assign out_free  = !out_valid_q || rsp.ready;

  assign req.ready = (cmd_i.op == OP_LOAD);

  always_comb begin
    flags_o.in_valid = req.valid;
    flags_o.kind     = kind_q;
    flags_o.inrange  = inrange;
    flags_o.have     = have;
    flags_o.empty    = (cnt_q == '0);
    flags_o.full     = (cnt_q == CNT_W'(CAPACITY));
    flags_o.s_zero   = (s_q == '0);
    flags_o.s_eq_cnt = (CNT_W'(s_q) == cnt_q);
    flags_o.key_gt   = $signed(hk_q) > $signed(old_q);
    flags_o.key_lt   = $signed(hk_q) < $signed(old_q);
    flags_o.up_stop  = $signed(ra_key) >= $signed(hk_q);
    flags_o.d_leaf   = c_x >= cnt_x;
    flags_o.d_stop   = $signed(hk_q) >= $signed(pick_key);
    flags_o.out_free = out_free;
  end

  always_comb begin
    addr_a = '0;
    addr_b = last_slot;
    case (cmd_i.op)
      OP_UP_RD:  addr_a = parent;
      OP_READ_S: addr_a = s_q;
      OP_D_RD: begin
        addr_a = c_x[SLOT_W-1:0];
        addr_b = c1_x[SLOT_W-1:0];
      end
      default: addr_a = '0;
    endcase
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = s_q;
    heap_wdata = {hk_q, hi_q};
    case (cmd_i.op)
      OP_UP_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = ra_q;
      end
      OP_D_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = {pick_key, pick_item};
      end
      OP_PUT: begin
        heap_we = 1'b1;
      end
      default: heap_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ra_q  <= heap_mem[addr_a];
    rb_q  <= heap_mem[addr_b];
    pos_q <= pos_mem[id_idx];
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
      pos_mem[heap_wdata[IDX_W-1:0]] <= heap_waddr;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q   <= req.kind;
        id_q     <= req.item_id;
        key_q    <= req.key;
        status_q <= ST_OK;
        kout_q   <= '0;
        iout_q   <= '0;
      end
      OP_ERR: status_q <= cmd_i.err;
      OP_INS: begin
        s_q    <= cnt_q[SLOT_W-1:0];
        hk_q   <= key_ext;
        hi_q   <= id_q;
        kout_q <= key_ext;
      end
      OP_PEEK: begin
        kout_q <= ra_key;
        iout_q <= ra_item;
      end
      OP_DEL: begin
        kout_q <= ra_key;
        iout_q <= ra_item;
        old_q  <= ra_key;
        s_q    <= '0;
        hk_q   <= rb_key;
        hi_q   <= rb_item;
      end
      OP_POS: begin
        s_q  <= pos_q;
        lk_q <= rb_key;
        li_q <= rb_item;
      end
      OP_UPD: begin
        old_q  <= ra_key;
        hk_q   <= key_ext;
        hi_q   <= ra_item;
        kout_q <= key_ext;
      end
      OP_REM: begin
        kout_q <= ra_key;
        old_q  <= ra_key;
        hk_q   <= lk_q;
        hi_q   <= li_q;
      end
      OP_RDK:     kout_q <= ra_key;
      OP_UP_MOVE: s_q <= parent;
      OP_D_MOVE:  s_q <= pick_slot;
      default: begin
      end
    endcase
    if (cmd_i.op == OP_FIN) begin
      o_status_q  <= status_q;
      o_key_q     <= KEY_W'(kout_q);
      o_item_q    <= iout_q;
      o_present_q <= have;
      o_count_q   <= COUNT_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_INS: begin
          cnt_q           <= cnt_q + CNT_W'(1);
          valid_q[id_idx] <= 1'b1;
        end
        OP_DEL, OP_REM: begin
          cnt_q                      <= cnt_q - CNT_W'(1);
          valid_q[ra_item[IDX_W-1:0]] <= 1'b0;
        end
        default: begin
        end
      endcase
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.status   = o_status_q;
  assign rsp.key_out  = o_key_q;
  assign rsp.item_out = o_item_q;
  assign rsp.present  = o_present_q;
  assign rsp.count    = o_count_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("Element count exceeds capacity.");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_INS) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("Insert did not grow the heap by one.");

  a_take_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DEL || cmd_i.op == OP_REM) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("Removal did not shrink the heap by one.");

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |-> out_free)
    else $error("Result overwritten before it was taken.");

endmodule
